// ----- rtl/clbb_pkg.sv -----
// shared types and constants of the color label bounding box block
`default_nettype none

package clbb_pkg;

  // default sizes
  localparam int CLBB_MAP_SLOTS  = 32;
  localparam int CLBB_AREA_COUNT = 32;
  localparam int CLBB_MAX_DIM    = 4096;

  // fixed field widths
  localparam int COLOR_W = 24;
  localparam int AREA_W  = 5;
  localparam int SLOT_W  = 5;
  localparam int POS_W   = 12;
  localparam int WIDTH_W = 13;

  // largest position count that the 12-bit counters can hold
  localparam int POS_CAP     = 1 << POS_W;
  localparam int WIDTH_RESET = 256;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_PIXEL = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    logic               entry_valid;
    logic [AREA_W-1:0]  entry_area;
    logic [COLOR_W-1:0] pixel_color;
    logic [AREA_W-1:0]  query_area;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic             empty_res;
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] top;
    logic [POS_W-1:0] right;
    logic [POS_W-1:0] bottom;
  } out_word_t;

  // map table write request
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  slot;
    logic               valid;
    logic [AREA_W-1:0]  area;
    logic [COLOR_W-1:0] color;
  } map_wr_t;

  // map lookup answer
  typedef struct packed {
    logic              hit;
    logic [AREA_W-1:0] area;
    logic              found;
  } lookup_t;

  // first stage word: positions already assigned
  typedef struct packed {
    op_t                op;
    logic [COLOR_W-1:0] color;
    logic [AREA_W-1:0]  qarea;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
  } s1_t;

  // later stage word: area resolved
  typedef struct packed {
    op_t               op;
    logic              hit;
    logic              found;
    logic [AREA_W-1:0] area;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
  } stage_t;

  // rectangle memory read request
  typedef struct packed {
    logic              en;
    logic [AREA_W-1:0] area;
  } rect_rd_t;

  typedef struct packed {
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] top;
    logic [POS_W-1:0] right;
    logic [POS_W-1:0] bottom;
  } rect_t;

endpackage

`default_nettype wire

// ----- rtl/clbb_map.sv -----
// color to area map table with parallel color and area match
`default_nettype none

module clbb_map
  import clbb_pkg::*;
#(
  parameter int MAP_SLOTS = CLBB_MAP_SLOTS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire map_wr_t            wr,
  input  wire logic [COLOR_W-1:0] lk_color,
  input  wire logic [AREA_W-1:0]  lk_area,
  output lookup_t                 lk
);

  localparam int SI_W = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;

  logic [MAP_SLOTS-1:0] valid_r;
  logic [COLOR_W-1:0]   color_r [MAP_SLOTS];
  logic [AREA_W-1:0]    area_r  [MAP_SLOTS];

  logic [SI_W+SLOT_W-1:0] slot_ext;
  logic [SI_W-1:0]        slot_idx;
  logic                   slot_ok;

  assign slot_ext = {{SI_W{1'b0}}, wr.slot};
  assign slot_idx = slot_ext[SI_W-1:0];
  assign slot_ok  = 32'(wr.slot) < MAP_SLOTS;

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en && slot_ok) begin
      valid_r[slot_idx] <= wr.valid;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (wr.en && slot_ok) begin
      color_r[slot_idx] <= wr.color;
      area_r[slot_idx]  <= wr.area;
    end
  end

  logic [MAP_SLOTS-1:0] cmatch;
  logic [MAP_SLOTS-1:0] amatch;
  logic [MAP_SLOTS-1:0] lowest;
  logic [AREA_W-1:0]    sel_area;

  // per entry compares
  always_comb begin
    for (int i = 0; i < MAP_SLOTS; i++) begin
      cmatch[i] = valid_r[i] && (color_r[i] == lk_color);
      amatch[i] = valid_r[i] && (area_r[i] == lk_area);
    end
  end

  // lowest matching slot wins
  assign lowest = cmatch & (~cmatch + MAP_SLOTS'(1));

  always_comb begin
    sel_area = '0;
    for (int i = 0; i < MAP_SLOTS; i++) begin
      sel_area = sel_area | ({AREA_W{lowest[i]}} & area_r[i]);
    end
  end

  assign lk.hit   = |cmatch;
  assign lk.area  = sel_area;
  assign lk.found = |amatch;

endmodule

`default_nettype wire

// ----- rtl/clbb_rect.sv -----
// rectangle memory with seen bits, read-modify-write and query answer
`default_nettype none

module clbb_rect
  import clbb_pkg::*;
#(
  parameter int AREA_COUNT = CLBB_AREA_COUNT
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire rect_rd_t rd,
  input  wire stage_t   s3,
  input  wire logic     s3_go,
  output out_word_t     res
);

  localparam int AI_W = (AREA_COUNT > 1) ? $clog2(AREA_COUNT) : 1;

  rect_t               mem [AREA_COUNT];
  logic [AREA_COUNT-1:0] seen_r;
  rect_t               rd_r;
  rect_t               byp_r;
  logic                coll_r;

  logic [AI_W+AREA_W-1:0] rd_ext;
  logic [AI_W-1:0]        rd_idx;
  logic [AI_W+AREA_W-1:0] s3_ext;
  logic [AI_W-1:0]        s3_idx;
  logic                   s3_in_range;

  assign rd_ext      = {{AI_W{1'b0}}, rd.area};
  assign rd_idx      = rd_ext[AI_W-1:0];
  assign s3_ext      = {{AI_W{1'b0}}, s3.area};
  assign s3_idx      = s3_ext[AI_W-1:0];
  assign s3_in_range = 32'(s3.area) < AREA_COUNT;

  logic  wr_en;
  logic  seen_bit;
  rect_t cur;
  rect_t wdata;

  assign wr_en    = s3_go && (s3.op == OP_PIXEL) && s3.hit && s3_in_range;
  assign seen_bit = s3_in_range && seen_r[s3_idx];
  // write in the same edge as this word's read: take the forwarded copy
  assign cur      = coll_r ? byp_r : rd_r;

  // grow rectangle, or open it on the area's first pixel of the frame
  always_comb begin
    if (!seen_bit) begin
      wdata.left   = s3.col;
      wdata.right  = s3.col;
      wdata.top    = s3.row;
      wdata.bottom = s3.row;
    end else begin
      wdata.left   = (s3.col < cur.left)   ? s3.col : cur.left;
      wdata.right  = (s3.col > cur.right)  ? s3.col : cur.right;
      wdata.top    = (s3.row < cur.top)    ? s3.row : cur.top;
      wdata.bottom = (s3.row > cur.bottom) ? s3.row : cur.bottom;
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s3_idx] <= wdata;
    end
  end

  // memory read port and forwarding capture
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_r   <= mem[rd_idx];
      byp_r  <= wdata;
      coll_r <= wr_en && (s3_idx == rd_idx);
    end
  end

  // seen bits, cleared at frame start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (s3_go && (s3.op == OP_START)) begin
      seen_r <= '0;
    end else if (wr_en) begin
      seen_r[s3_idx] <= 1'b1;
    end
  end

  // query answer
  logic found_q;
  logic empty_q;

  assign found_q       = s3.found && s3_in_range;
  assign empty_q       = !(found_q && seen_bit);
  assign res.found     = found_q;
  assign res.empty_res = empty_q;
  assign res.left      = empty_q ? '0 : cur.left;
  assign res.top       = empty_q ? '0 : cur.top;
  assign res.right     = empty_q ? '0 : cur.right;
  assign res.bottom    = empty_q ? '0 : cur.bottom;

  a_start_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (s3_go && (s3.op == OP_START)) |=> (seen_r == '0))
    else $error("seen bits not cleared by frame start");

  a_write_sets_seen : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> seen_r[$past(s3_idx)])
    else $error("rectangle written without seen bit");

  a_write_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (32'(s3.area) < AREA_COUNT))
    else $error("rectangle write outside area count");

endmodule

`default_nettype wire

// ----- rtl/color_label_bounding_boxes_core.sv -----
// A query word is registered in s1, s2 and s3, then in the output register.
// Throughput: one word per cycle unless out_stall holds back a query; pixels, loads and
// starts make no result. The rate is set by the rectangle memory read-modify-write
// (one read and one write port), with a forwarding register when consecutive pixels
// hit the same area. Reset (synchronous, rst_n low) clears pipeline valids, map valid
// bits, seen bits and position counters; row width returns to 256.
`default_nettype none

module color_label_bounding_boxes_core
  import clbb_pkg::*;
#(
  parameter int MAP_SLOTS  = CLBB_MAP_SLOTS,
  parameter int AREA_COUNT = CLBB_AREA_COUNT,
  parameter int MAX_DIM    = CLBB_MAX_DIM
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_word_t           in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_word_t               out_word,
  input  wire logic               cfg_wr_en,
  input  wire logic [WIDTH_W-1:0] cfg_wr_data
);

  localparam int POS_LIMIT = (MAX_DIM < POS_CAP) ? MAX_DIM : POS_CAP;

  // pipeline registers
  logic      s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  s1_t       s1_r;
  stage_t    s2_r, s3_r;
  out_word_t out_word_r;

  logic s1_go, s2_go, s3_go, out_free, accept;

  // stage flow: a stage moves when the one after is empty or moving
  assign out_free = !out_valid_r || !out_stall;
  assign s3_go    = s3_v_r && ((s3_r.op != OP_QUERY) || out_free);
  assign s2_go    = s2_v_r && (!s3_v_r || s3_go);
  assign s1_go    = s1_v_r && (!s2_v_r || s2_go);
  assign in_stall = s1_v_r && !s1_go;
  assign accept   = in_valid && !in_stall;

  // clamped row width register
  logic [WIDTH_W-1:0] eff_w_r;
  logic [WIDTH_W-1:0] eff_w_nxt;

  always_comb begin
    if (cfg_wr_data == '0) begin
      eff_w_nxt = WIDTH_W'(1);
    end else if (32'(cfg_wr_data) > POS_LIMIT) begin
      eff_w_nxt = WIDTH_W'(POS_LIMIT);
    end else begin
      eff_w_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= WIDTH_W'((WIDTH_RESET < POS_LIMIT) ? WIDTH_RESET : POS_LIMIT);
    end else if (cfg_wr_en) begin
      eff_w_r <= eff_w_nxt;
    end
  end

  // position counters, advanced as pixel words are accepted, cleared by a start
  logic [POS_W-1:0] col_r, row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept && (in_word.op == OP_START)) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept && (in_word.op == OP_PIXEL)) begin
      if (({1'b0, col_r} + WIDTH_W'(1)) >= eff_w_r) begin
        col_r <= '0;
        if ((32'(row_r) + 1) < POS_LIMIT) begin
          row_r <= row_r + POS_W'(1);
        end
      end else begin
        col_r <= col_r + POS_W'(1);
      end
    end
  end

  // map table, written in order at accept
  map_wr_t map_wr;
  lookup_t lk;

  assign map_wr.en    = accept && (in_word.op == OP_LOAD);
  assign map_wr.slot  = in_word.slot;
  assign map_wr.valid = in_word.entry_valid;
  assign map_wr.area  = in_word.entry_area;
  assign map_wr.color = in_word.pixel_color;

  clbb_map #(
    .MAP_SLOTS(MAP_SLOTS)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (map_wr),
    .lk_color(s1_r.color),
    .lk_area (s1_r.qarea),
    .lk      (lk)
  );

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        s2_v_r <= 1'b1;
      end else if (s2_go) begin
        s2_v_r <= 1'b0;
      end
      if (s2_go) begin
        s3_v_r <= 1'b1;
      end else if (s3_go) begin
        s3_v_r <= 1'b0;
      end
      if (s3_go && (s3_r.op == OP_QUERY)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // stage payloads
  out_word_t res;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.op    <= in_word.op;
      s1_r.color <= in_word.pixel_color;
      s1_r.qarea <= in_word.query_area;
      s1_r.col   <= col_r;
      s1_r.row   <= row_r;
    end
    if (s1_go) begin
      s2_r.op    <= s1_r.op;
      s2_r.hit   <= lk.hit;
      s2_r.found <= lk.found;
      s2_r.area  <= (s1_r.op == OP_QUERY) ? s1_r.qarea : lk.area;
      s2_r.col   <= s1_r.col;
      s2_r.row   <= s1_r.row;
    end
    if (s2_go) begin
      s3_r <= s2_r;
    end
    if (s3_go && (s3_r.op == OP_QUERY)) begin
      out_word_r <= res;
    end
  end

  // rectangle store: read in stage two, update or answer in stage three
  rect_rd_t rect_rd;

  assign rect_rd.en   = s2_go;
  assign rect_rd.area = s2_r.area;

  clbb_rect #(
    .AREA_COUNT(AREA_COUNT)
  ) u_rect (
    .clk  (clk),
    .rst_n(rst_n),
    .rd   (rect_rd),
    .s3   (s3_r),
    .s3_go(s3_go),
    .res  (res)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_free_output_flows : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled while output register is free");

  a_query_gives_word : assert property (@(posedge clk) disable iff (!rst_n)
    (s3_go && (s3_r.op == OP_QUERY)) |=> out_valid_r)
    else $error("query left stage three without a result word");

  a_row_bound : assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_r) < POS_LIMIT)
    else $error("row counter past its limit");

endmodule

`default_nettype wire

// ----- sim/color_label_bounding_boxes_core_tb.sv -----
// testbench for the color label bounding box core: scoreboard with predictor, drivers, checks
`default_nettype none

module color_label_bounding_boxes_core_tb
  import clbb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // predicts query answers from the map table and per-area rectangles
  class bbox_scoreboard;
    bit [COLOR_W-1:0] slot_color [CLBB_MAP_SLOTS];
    bit [AREA_W-1:0]  slot_area  [CLBB_MAP_SLOTS];
    bit               slot_valid [CLBB_MAP_SLOTS];
    bit               box_seen   [CLBB_AREA_COUNT];
    int unsigned      box_left   [CLBB_AREA_COUNT];
    int unsigned      box_top    [CLBB_AREA_COUNT];
    int unsigned      box_right  [CLBB_AREA_COUNT];
    int unsigned      box_bottom [CLBB_AREA_COUNT];
    int unsigned      col_pos;
    int unsigned      row_pos;
    bit [WIDTH_W-1:0] row_width;
    out_word_t        expected_boxes[$];
    int               mismatches;
    int               checked;

    function new();
      row_width = WIDTH_W'(WIDTH_RESET);
      foreach (slot_valid[i]) begin
        slot_color[i] = '0;
        slot_area[i]  = '0;
        slot_valid[i] = 1'b0;
      end
      clear_boxes();
      mismatches = 0;
      checked    = 0;
    endfunction

    // start of frame: every rectangle empty, position back to the origin
    function void clear_boxes();
      foreach (box_seen[i]) begin
        box_seen[i]   = 1'b0;
        box_left[i]   = 0;
        box_top[i]    = 0;
        box_right[i]  = 0;
        box_bottom[i] = 0;
      end
      col_pos = 0;
      row_pos = 0;
    endfunction

    function int pending();
      return expected_boxes.size();
    endfunction

    // advance the model by one accepted input word
    function void note_input(in_word_t w);
      int unsigned eff;
      int unsigned hit;
      int unsigned a;
      bit          found;
      out_word_t   exp_box;
      case (w.op)
        OP_LOAD: begin
          slot_color[w.slot] = w.pixel_color;
          slot_valid[w.slot] = w.entry_valid;
          slot_area[w.slot]  = w.entry_area;
        end
        OP_START: begin
          clear_boxes();
        end
        OP_PIXEL: begin
          // zero width acts as one, oversize widths clip to the counter range
          eff = (row_width == 0) ? 1 : row_width;
          if (eff > POS_CAP) eff = POS_CAP;
          // lowest valid slot with this color wins
          hit = CLBB_MAP_SLOTS;
          for (int i = CLBB_MAP_SLOTS - 1; i >= 0; i--) begin
            if (slot_valid[i] && slot_color[i] == w.pixel_color) hit = i;
          end
          if (hit < CLBB_MAP_SLOTS) begin
            a = slot_area[hit];
            if (a < CLBB_AREA_COUNT) begin
              if (!box_seen[a]) begin
                box_seen[a]   = 1'b1;
                box_left[a]   = col_pos;
                box_right[a]  = col_pos;
                box_top[a]    = row_pos;
                box_bottom[a] = row_pos;
              end else begin
                if (col_pos < box_left[a])   box_left[a]   = col_pos;
                if (col_pos > box_right[a])  box_right[a]  = col_pos;
                if (row_pos < box_top[a])    box_top[a]    = row_pos;
                if (row_pos > box_bottom[a]) box_bottom[a] = row_pos;
              end
            end
          end
          // column wraps at the width, row saturates at the last row
          if (col_pos + 1 >= eff) begin
            col_pos = 0;
            if (row_pos + 1 < POS_CAP) row_pos++;
          end else begin
            col_pos++;
          end
        end
        OP_QUERY: begin
          found = 1'b0;
          if (w.query_area < CLBB_AREA_COUNT) begin
            foreach (slot_valid[i]) begin
              if (slot_valid[i] && slot_area[i] == w.query_area) found = 1'b1;
            end
          end
          exp_box           = '0;
          exp_box.found     = found;
          exp_box.empty_res = !(found && box_seen[w.query_area]);
          if (!exp_box.empty_res) begin
            exp_box.left   = POS_W'(box_left[w.query_area]);
            exp_box.top    = POS_W'(box_top[w.query_area]);
            exp_box.right  = POS_W'(box_right[w.query_area]);
            exp_box.bottom = POS_W'(box_bottom[w.query_area]);
          end
          expected_boxes.push_back(exp_box);
        end
        default: begin
        end
      endcase
    endfunction

    // compare one result word against the oldest predicted answer
    function void check_result(out_word_t got);
      out_word_t exp_box;
      bit        bad;
      if (expected_boxes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing pending: found=%0d empty=%0d %0d %0d %0d %0d",
                   $realtime, got.found, got.empty_res, got.left, got.top, got.right,
                   got.bottom);
        return;
      end
      exp_box = expected_boxes.pop_front();
      checked++;
      bad = (got.found != exp_box.found) || (got.empty_res != exp_box.empty_res) ||
            (got.left != exp_box.left) || (got.top != exp_box.top) ||
            (got.right != exp_box.right) || (got.bottom != exp_box.bottom);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: box mismatch", $realtime);
          $display("  expected found=%0d empty=%0d l=%0d t=%0d r=%0d b=%0d",
                   exp_box.found, exp_box.empty_res, exp_box.left, exp_box.top,
                   exp_box.right, exp_box.bottom);
          $display("  actual   found=%0d empty=%0d l=%0d t=%0d r=%0d b=%0d",
                   got.found, got.empty_res, got.left, got.top, got.right, got.bottom);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_word_t           in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_word;
  logic               cfg_wr_en = 1'b0;
  logic [WIDTH_W-1:0] cfg_wr_data = '0;

  bbox_scoreboard     sb = new();
  int                 idle_mode = 0;
  int                 stall_mode = 0;
  int                 stall_left = 0;
  int                 words_sent = 0;
  int                 width_writes = 0;
  bit [COLOR_W-1:0]   palette [8];
  bit [AREA_W-1:0]    area_set [8];

  color_label_bounding_boxes_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // result side back-pressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_mode != 0 && $urandom_range(0, 99) < 25) begin
      out_stall  <= 1'b1;
      stall_left <= (stall_mode == 2 && $urandom_range(0, 9) == 0) ?
                    $urandom_range(5, 30) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
  end

  // run limit
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (idle_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93 || idle_mode == 1) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // random filler in the fields that the operation does not use
  function automatic in_word_t op_word(op_t op);
    logic [63:0] r;
    in_word_t    w;
    r    = {$urandom(), $urandom()};
    w    = in_word_t'(r[$bits(in_word_t)-1:0]);
    w.op = op;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w);
    words_sent++;
  endtask

  task automatic send_load(bit [SLOT_W-1:0] slot, bit vld, bit [AREA_W-1:0] area,
                           bit [COLOR_W-1:0] color);
    in_word_t w;
    w             = op_word(OP_LOAD);
    w.slot        = slot;
    w.entry_valid = vld;
    w.entry_area  = area;
    w.pixel_color = color;
    send_word(w);
  endtask

  task automatic send_start();
    send_word(op_word(OP_START));
  endtask

  task automatic send_pixel(bit [COLOR_W-1:0] color);
    in_word_t w;
    w             = op_word(OP_PIXEL);
    w.pixel_color = color;
    send_word(w);
  endtask

  task automatic send_query(bit [AREA_W-1:0] area);
    in_word_t w;
    w            = op_word(OP_QUERY);
    w.query_area = area;
    send_word(w);
  endtask

  // hold the sender until every pending answer is back and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_row_width(bit [WIDTH_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    sb.row_width = v;
    width_writes++;
  endtask

  function automatic bit [COLOR_W-1:0] pick_color();
    if ($urandom_range(0, 99) < 85) return palette[$urandom_range(0, 7)];
    return COLOR_W'($urandom_range(0, 24'hFFFFFF));
  endfunction

  function automatic bit [AREA_W-1:0] pick_area();
    if ($urandom_range(0, 3) != 0) return area_set[$urandom_range(0, 7)];
    return AREA_W'($urandom_range(0, 31));
  endfunction

  // fresh small set of colors and areas so pixels keep hitting the map
  task automatic new_palette();
    foreach (palette[i]) begin
      palette[i]  = COLOR_W'($urandom_range(0, 24'hFFFFFF));
      area_set[i] = AREA_W'($urandom_range(0, 31));
    end
    if ($urandom_range(0, 3) == 0) palette[0] = '0;
    if ($urandom_range(0, 3) == 0) palette[7] = '1;
    if ($urandom_range(0, 3) == 0) area_set[0] = '0;
    if ($urandom_range(0, 3) == 0) area_set[7] = '1;
  endtask

  // one width setting: optional new palette and frame, map loads, mixed traffic, then queries
  task automatic run_phase(bit [WIDTH_W-1:0] width);
    int r;
    int n;
    idle_mode  = $urandom_range(0, 9) < 3 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
    stall_mode = $urandom_range(0, 9) < 3 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
    set_row_width(width);
    if ($urandom_range(0, 3) == 0) new_palette();
    if ($urandom_range(0, 1)) send_start();
    repeat ($urandom_range(0, 6))
      send_load(SLOT_W'($urandom_range(0, 31)), $urandom_range(0, 7) != 0,
                area_set[$urandom_range(0, 7)], palette[$urandom_range(0, 7)]);
    n = $urandom_range(20, 120);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 60) send_pixel(pick_color());
      else if (r < 82) send_query(pick_area());
      else if (r < 88)
        send_load(SLOT_W'($urandom_range(0, 31)), $urandom_range(0, 5) != 0,
                  pick_area(), pick_color());
      else if (r < 91) send_start();
      else send_word(op_word(op_t'($urandom_range(0, 3))));
      if ($urandom_range(0, 99) < 2) drain();
    end
    foreach (area_set[i]) send_query(area_set[i]);
  endtask

  initial begin
    bit [WIDTH_W-1:0] special_widths [8];
    bit [WIDTH_W-1:0] w;
    int               phase;
    int               r;

    special_widths = '{1, 4096, 5, 8191, 2, 4097, 3, 64};
    new_palette();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, slot priority, invalid slots, unmatched colors
    send_query(0);
    send_query(31);
    send_load(0, 1'b1, 0, 24'h000000);
    send_load(31, 1'b1, 31, 24'hFFFFFF);
    send_load(1, 1'b1, 5, 24'hFFFFFF);
    send_load(2, 1'b0, 7, 24'h123456);
    send_query(31);
    send_start();
    send_pixel(24'hFFFFFF);
    send_pixel(24'h123456);
    send_pixel(24'hABCDEF);
    send_pixel(24'h000000);
    send_query(5);
    send_query(0);
    send_query(31);
    send_query(7);
    // shrink width below the current column, then wrap
    set_row_width(2);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_query(5);
    send_query(0);
    // dropping slot one hands the color to the higher slot
    send_load(1, 1'b0, 5, 24'hFFFFFF);
    send_pixel(24'hFFFFFF);
    send_query(31);
    send_query(5);

    // zero width acts as one: every pixel starts a new row
    stall_mode = 1;
    set_row_width(0);
    send_load(3, 1'b1, 3, 24'h00FF00);
    send_load(4, 1'b1, 4, 24'h0000FF);
    send_start();
    for (int i = 0; i < 120; i++) begin
      send_pixel(i >= 110 ? 24'h0000FF : 24'h00FF00);
      if (i % 40 == 39) send_query(3);
    end
    send_query(3);
    send_query(4);

    // random phases
    phase = 0;
    while (words_sent < 1700) begin
      if (phase < 8) begin
        w = special_widths[phase];
      end else begin
        r = $urandom_range(0, 9);
        w = r < 7 ? WIDTH_W'($urandom_range(1, 64)) :
            (r < 9 ? WIDTH_W'($urandom_range(65, 4096)) : WIDTH_W'($urandom_range(0, 8191)));
      end
      run_phase(w);
      phase++;
    end

    drain();
    $display("%0d input words, %0d query answers checked, %0d row width writes",
             words_sent, sb.checked, width_writes);
    $display("covered zero and oversize widths, slot priority and width changes mid-row");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/clbb_pkg.sv
rtl/clbb_map.sv
rtl/clbb_rect.sv
rtl/color_label_bounding_boxes_core.sv
sim/color_label_bounding_boxes_core_tb.sv
